// ===== sv/wspl_pkg.sv =====
// Shared types, constants and helper functions for the wheel speed PID loop.
package wspl_pkg;

    // Shared arithmetic unit sizing
    localparam int UnitW = 64;
    localparam int CntW  = 7;
    localparam int DvsW  = 16;

    // Operand bit counts for each pass through the shared unit
    localparam logic [CntW-1:0] RECIP_BITS  = 7'd10;  // 1000 fits in 10 bits
    localparam logic [CntW-1:0] FACTOR_BITS = 7'd20;  // 600 * 1000 fits in 20 bits
    localparam logic [CntW-1:0] SPEED_BITS  = 7'd52;  // 2^31 * 600000 fits in 52 bits
    localparam logic [CntW-1:0] GAIN_BITS   = 7'd16;
    localparam logic [CntW-1:0] DTERM_BITS  = 7'd41;  // Kd * derr fits in 41 bits

    localparam logic [9:0]  RECIP_NUM   = 10'd1000;
    localparam logic [19:0] FACTOR_MULT = 20'd600;    // 60 s/min times 10
    localparam logic [7:0]  DUTY_MAX    = 8'd255;

    // Register map
    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_KP     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_KI     = 3'd3;
    localparam logic [2:0] REG_CPR    = 3'd4;

    localparam logic [10:0] TARGET_RST = 11'd50;
    localparam logic [15:0] KP_RST     = 16'd640;
    localparam logic [15:0] KD_RST     = 16'd77;
    localparam logic [15:0] KI_RST     = 16'd26;
    localparam logic [15:0] CPR_RST    = 16'd9792;

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [UnitW-1:0] a;
        logic [UnitW-1:0] b;
        logic [CntW-1:0]  count;
    } alu_req_t;

    typedef struct packed {
        logic             done;
        logic [UnitW-1:0] result;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RECIP,
        ST_SPD_MUL,
        ST_SPD_DIV,
        ST_ERR,
        ST_INT_MUL,
        ST_INT_ACC,
        ST_P_MUL,
        ST_D_MUL,
        ST_D_DIV,
        ST_I_MUL,
        ST_SUM,
        ST_DRIVE,
        ST_OUT
    } state_t;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end
        else if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sd140737488355327) begin
            return 48'sh7FFFFFFFFFFF;
        end
        else if (v < -64'sd140737488355328) begin
            return 48'sh800000000000;
        end
        return v[47:0];
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== sv/wspl_alu.sv =====
// Shared bit-serial unsigned multiply and divide unit, one operand bit per cycle.
module wspl_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  wspl_pkg::alu_req_t req,
    output wspl_pkg::alu_rsp_t rsp
);

    wspl_pkg::alu_op_t                op_reg;
    logic [wspl_pkg::UnitW-1:0]       acc_reg;
    logic [wspl_pkg::UnitW-1:0]       a_reg;
    logic [wspl_pkg::UnitW-1:0]       b_reg;
    logic [wspl_pkg::DvsW-1:0]        dvs_reg;
    logic [wspl_pkg::DvsW-1:0]        rem_reg;
    logic [wspl_pkg::CntW-1:0]        cnt_reg;
    logic                             done_reg;

    logic [wspl_pkg::DvsW:0]          shifted;
    logic                             fits;
    logic [wspl_pkg::DvsW:0]          diff;

    assign shifted = {rem_reg, acc_reg[wspl_pkg::UnitW-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start) begin
            cnt_reg  <= req.count;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= (cnt_reg == 7'd1);
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk) begin
        if (req.start) begin
            op_reg  <= req.op;
            a_reg   <= req.a;
            b_reg   <= req.b;
            dvs_reg <= req.b[wspl_pkg::DvsW-1:0];
            rem_reg <= '0;
            if (req.op == wspl_pkg::ALU_DIV) begin
                // park the dividend at the top so its bits shift out first
                acc_reg <= req.a << (7'd64 - req.count);
            end
            else begin
                acc_reg <= '0;
            end
        end
        else if (cnt_reg != '0) begin
            unique case (op_reg)
                wspl_pkg::ALU_MUL: begin
                    if (b_reg[0]) begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= {a_reg[wspl_pkg::UnitW-2:0], 1'b0};
                    b_reg <= {1'b0, b_reg[wspl_pkg::UnitW-1:1]};
                end
                wspl_pkg::ALU_DIV: begin
                    rem_reg <= fits ? diff[wspl_pkg::DvsW-1:0] : shifted[wspl_pkg::DvsW-1:0];
                    acc_reg <= {acc_reg[wspl_pkg::UnitW-2:0], fits};
                end
                default: ;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// ===== sv/wheel_speed_pid_loop_core.sv =====
// Top level of the wheel speed PID loop: APB registers, sequencer and result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, encoder_count, elapsed_ms | into core
//  out     | out_valid, out_stall, speed_rpm, speed_error, drive_value, pwm_duty | out of core
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB slave
//
// One tick makes eight passes through the shared bit-serial unit, one for
// each operand of 10, 20, 52, 16, 16, 16, 41 and 16 bits, plus five further
// steps. The unit handles one bit per cycle and so sets the length of a tick.
// in_stall is high from the transfer of a tick until its result sits in the
// output register; a result not yet taken holds there while the next tick runs.
// Reset restores the register defaults and clears the count, error and integral.
module wheel_speed_pid_loop_core (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] encoder_count,
    input  logic [15:0]        elapsed_ms,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] speed_rpm,
    output logic signed [23:0] speed_error,
    output logic signed [23:0] drive_value,
    output logic [7:0]         pwm_duty,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic signed [10:0] target_reg;
    logic [15:0]        kp_reg;
    logic [15:0]        kd_reg;
    logic [15:0]        ki_reg;
    logic [15:0]        cpr_reg;

    // Loop state
    logic [31:0]        last_count_reg;
    logic signed [23:0] last_error_reg;
    logic signed [47:0] integral_reg;

    // Sequencer
    wspl_pkg::state_t   state_reg;
    wspl_pkg::state_t   state_next;
    logic               issued_reg;
    logic               issued_next;
    logic               unit_state;

    // Per-tick working values
    logic [15:0]        dt_reg;
    logic [31:0]        delta_mag_reg;
    logic               delta_neg_reg;
    logic [9:0]         recip_reg;
    logic [63:0]        prod_reg;
    logic signed [23:0] speed_reg;
    logic signed [23:0] err_reg;
    logic signed [24:0] derr_reg;
    logic signed [40:0] t_reg;
    logic signed [40:0] p_reg;
    logic signed [41:0] d_reg;
    logic signed [63:0] i_reg;
    logic signed [63:0] sum_reg;
    logic signed [23:0] drive_reg;

    // Result register
    logic               out_valid_reg;
    logic signed [23:0] speed_out_reg;
    logic signed [23:0] error_out_reg;
    logic signed [23:0] drive_out_reg;
    logic [7:0]         duty_out_reg;

    wspl_pkg::alu_req_t alu_req;
    wspl_pkg::alu_rsp_t alu_rsp;

    logic               in_xfer;
    logic               out_load;
    logic               cfg_write;
    logic [2:0]         cfg_idx;
    logic [31:0]        delta;
    logic [19:0]        factor;
    logic [15:0]        cpr_eff;
    logic [23:0]        err_mag;
    logic [24:0]        derr_mag;
    logic [47:0]        int_mag;
    logic signed [24:0] err_diff;
    logic signed [23:0] err_new;
    logic signed [63:0] sum_adj;
    logic signed [63:0] sum_div;
    logic [24:0]        drive_mag;
    logic [7:0]         duty;

    assign in_xfer   = in_valid && !in_stall;
    assign out_load  = (state_reg == wspl_pkg::ST_OUT) && (!out_valid_reg || !out_stall);
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    assign delta    = encoder_count - last_count_reg;
    assign factor   = 20'(recip_reg) * wspl_pkg::FACTOR_MULT;
    assign cpr_eff  = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;
    assign err_mag  = err_reg[23] ? 24'(-err_reg) : 24'(err_reg);
    assign derr_mag = derr_reg[24] ? 25'(-derr_reg) : 25'(derr_reg);
    assign int_mag  = integral_reg[47] ? 48'(-integral_reg) : 48'(integral_reg);
    assign err_diff = 25'(target_reg) - 25'(speed_reg);
    assign err_new  = wspl_pkg::sat24(64'(err_diff));

    // Round the Q56.8 sum toward zero before dropping the fraction
    assign sum_adj  = sum_reg + (sum_reg[63] ? 64'sd255 : 64'sd0);
    assign sum_div  = sum_adj >>> 8;

    assign drive_mag = drive_reg[23] ? 25'(-25'(drive_reg)) : 25'(drive_reg);
    assign duty      = (drive_mag > 25'(wspl_pkg::DUTY_MAX)) ? wspl_pkg::DUTY_MAX
                                                             : drive_mag[7:0];

    // ---------------------------------------------------------------- APB port
    assign pready = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            wspl_pkg::REG_TARGET: prdata = 32'(unsigned'(target_reg));
            wspl_pkg::REG_KP:     prdata = 32'(kp_reg);
            wspl_pkg::REG_KD:     prdata = 32'(kd_reg);
            wspl_pkg::REG_KI:     prdata = 32'(ki_reg);
            wspl_pkg::REG_CPR:    prdata = 32'(cpr_reg);
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            target_reg <= wspl_pkg::TARGET_RST;
            kp_reg     <= wspl_pkg::KP_RST;
            kd_reg     <= wspl_pkg::KD_RST;
            ki_reg     <= wspl_pkg::KI_RST;
            cpr_reg    <= wspl_pkg::CPR_RST;
        end
        else if (cfg_write) begin
            unique case (cfg_idx)
                wspl_pkg::REG_TARGET: target_reg <= pwdata[10:0];
                wspl_pkg::REG_KP:     kp_reg     <= pwdata[15:0];
                wspl_pkg::REG_KD:     kd_reg     <= pwdata[15:0];
                wspl_pkg::REG_KI:     ki_reg     <= pwdata[15:0];
                wspl_pkg::REG_CPR:    cpr_reg    <= pwdata[15:0];
                default: ;  // unmapped addresses drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        unit_state = (state_reg == wspl_pkg::ST_RECIP)   || (state_reg == wspl_pkg::ST_SPD_MUL) ||
                     (state_reg == wspl_pkg::ST_SPD_DIV) || (state_reg == wspl_pkg::ST_INT_MUL) ||
                     (state_reg == wspl_pkg::ST_P_MUL)   || (state_reg == wspl_pkg::ST_D_MUL)   ||
                     (state_reg == wspl_pkg::ST_D_DIV)   || (state_reg == wspl_pkg::ST_I_MUL);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wspl_pkg::ST_IDLE:    if (in_xfer) state_next = wspl_pkg::ST_RECIP;
            wspl_pkg::ST_RECIP:   if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_SPD_MUL;
            wspl_pkg::ST_SPD_MUL: if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_SPD_DIV;
            wspl_pkg::ST_SPD_DIV: if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_ERR;
            wspl_pkg::ST_ERR:     state_next = wspl_pkg::ST_INT_MUL;
            wspl_pkg::ST_INT_MUL: if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_INT_ACC;
            wspl_pkg::ST_INT_ACC: state_next = wspl_pkg::ST_P_MUL;
            wspl_pkg::ST_P_MUL:   if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_D_MUL;
            wspl_pkg::ST_D_MUL:   if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_D_DIV;
            wspl_pkg::ST_D_DIV:   if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_I_MUL;
            wspl_pkg::ST_I_MUL:   if (issued_reg && alu_rsp.done) state_next = wspl_pkg::ST_SUM;
            wspl_pkg::ST_SUM:     state_next = wspl_pkg::ST_DRIVE;
            wspl_pkg::ST_DRIVE:   state_next = wspl_pkg::ST_OUT;
            wspl_pkg::ST_OUT:     if (out_load) state_next = wspl_pkg::ST_IDLE;
            default:              state_next = wspl_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: the unit request and handshake flags
    always_comb begin
        alu_req       = '0;
        alu_req.op    = wspl_pkg::ALU_MUL;
        issued_next   = 1'b0;
        in_stall      = (state_reg != wspl_pkg::ST_IDLE);
        unique case (state_reg)
            wspl_pkg::ST_RECIP: begin
                alu_req.op    = wspl_pkg::ALU_DIV;
                alu_req.a     = 64'(wspl_pkg::RECIP_NUM);
                alu_req.b     = 64'(dt_reg);
                alu_req.count = wspl_pkg::RECIP_BITS;
            end
            wspl_pkg::ST_SPD_MUL: begin
                alu_req.a     = 64'(delta_mag_reg);
                alu_req.b     = 64'(factor);
                alu_req.count = wspl_pkg::FACTOR_BITS;
            end
            wspl_pkg::ST_SPD_DIV: begin
                alu_req.op    = wspl_pkg::ALU_DIV;
                alu_req.a     = prod_reg;
                alu_req.b     = 64'(cpr_eff);
                alu_req.count = wspl_pkg::SPEED_BITS;
            end
            wspl_pkg::ST_INT_MUL: begin
                alu_req.a     = 64'(err_mag);
                alu_req.b     = 64'(dt_reg);
                alu_req.count = wspl_pkg::GAIN_BITS;
            end
            wspl_pkg::ST_P_MUL: begin
                alu_req.a     = 64'(err_mag);
                alu_req.b     = 64'(kp_reg);
                alu_req.count = wspl_pkg::GAIN_BITS;
            end
            wspl_pkg::ST_D_MUL: begin
                alu_req.a     = 64'(derr_mag);
                alu_req.b     = 64'(kd_reg);
                alu_req.count = wspl_pkg::GAIN_BITS;
            end
            wspl_pkg::ST_D_DIV: begin
                alu_req.op    = wspl_pkg::ALU_DIV;
                alu_req.a     = prod_reg;
                alu_req.b     = 64'(dt_reg);
                alu_req.count = wspl_pkg::DTERM_BITS;
            end
            wspl_pkg::ST_I_MUL: begin
                alu_req.a     = 64'(int_mag);
                alu_req.b     = 64'(ki_reg);
                alu_req.count = wspl_pkg::GAIN_BITS;
            end
            default: ;
        endcase
        // Kick the unit once on entry, then wait for its done pulse
        alu_req.start = unit_state && !issued_reg;
        if (unit_state) begin
            issued_next = !(issued_reg && alu_rsp.done);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= wspl_pkg::ST_IDLE;
            issued_reg <= 1'b0;
        end
        else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    wspl_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // ---------------------------------------------------------------- loop state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            last_count_reg <= '0;
            last_error_reg <= '0;
            integral_reg   <= '0;
        end
        else begin
            if (in_xfer) begin
                last_count_reg <= encoder_count;
            end
            if (state_reg == wspl_pkg::ST_ERR) begin
                last_error_reg <= err_new;
            end
            if (state_reg == wspl_pkg::ST_INT_ACC) begin
                // windup stops at the 48-bit limits
                integral_reg <= wspl_pkg::sat48(64'(integral_reg) + 64'(t_reg));
            end
        end
    end

    // ---------------------------------------------------------------- working values
    always_ff @(posedge clk) begin
        if (in_xfer) begin
            dt_reg        <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
            delta_neg_reg <= delta[31];
            delta_mag_reg <= delta[31] ? -delta : delta;
        end
        if (issued_reg && alu_rsp.done) begin
            unique case (state_reg)
                wspl_pkg::ST_RECIP:   recip_reg <= alu_rsp.result[9:0];
                wspl_pkg::ST_SPD_MUL: prod_reg  <= alu_rsp.result;
                wspl_pkg::ST_SPD_DIV:
                    speed_reg <= wspl_pkg::sat24(wspl_pkg::apply_sign(alu_rsp.result,
                                                                       delta_neg_reg));
                wspl_pkg::ST_INT_MUL:
                    t_reg <= 41'(wspl_pkg::apply_sign(alu_rsp.result, err_reg[23]));
                wspl_pkg::ST_P_MUL:
                    p_reg <= 41'(wspl_pkg::apply_sign(alu_rsp.result, err_reg[23]));
                wspl_pkg::ST_D_MUL:   prod_reg  <= alu_rsp.result;
                wspl_pkg::ST_D_DIV:
                    d_reg <= 42'(wspl_pkg::apply_sign(alu_rsp.result, derr_reg[24]));
                wspl_pkg::ST_I_MUL:
                    i_reg <= wspl_pkg::apply_sign(alu_rsp.result, integral_reg[47]);
                default: ;
            endcase
        end
        if (state_reg == wspl_pkg::ST_ERR) begin
            err_reg  <= err_new;
            derr_reg <= 25'(err_new) - 25'(last_error_reg);
        end
        if (state_reg == wspl_pkg::ST_SUM) begin
            sum_reg <= i_reg + 64'(p_reg) + 64'(d_reg);
        end
        if (state_reg == wspl_pkg::ST_DRIVE) begin
            drive_reg <= wspl_pkg::sat24(sum_div);
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            speed_out_reg <= speed_reg;
            error_out_reg <= err_reg;
            drive_out_reg <= drive_reg;
            duty_out_reg  <= duty;
        end
    end

    assign out_valid   = out_valid_reg;
    assign speed_rpm   = speed_out_reg;
    assign speed_error = error_out_reg;
    assign drive_value = drive_out_reg;
    assign pwm_duty    = duty_out_reg;

endmodule

// ===== sv/wspl_checker.sv =====
// Port-level checker for the wheel speed PID loop and its bind to the top level.
module wspl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [23:0] speed_rpm,
    input logic signed [23:0] speed_error,
    input logic signed [23:0] drive_value,
    input logic [7:0]         pwm_duty
);

    logic [24:0] drive_mag;
    logic [7:0]  duty_exp;

    assign drive_mag = drive_value[23] ? 25'(-25'(drive_value)) : 25'(drive_value);
    assign duty_exp  = (drive_mag > 25'd255) ? 8'd255 : drive_mag[7:0];

    // A transfer in starts a multi-cycle tick: hold off the next one
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken on the cycle after a transfer");

    // Duty is the drive magnitude clamped to 8 bits
    a_duty_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pwm_duty == duty_exp))
        else $error("pwm_duty does not match drive_value");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(speed_rpm) && $stable(speed_error) &&
                                      $stable(drive_value)))
        else $error("stalled result changed");

endmodule

bind wheel_speed_pid_loop_core wspl_checker u_wspl_checker (.*);
